// File: hdl/hmbs_pkg.sv
// Shared constants, types and helpers of the heightmap bilinear sampler.
`timescale 1ns / 1ps

package hmbs_pkg;

    localparam int MAP_SIDE_MAX_DEF = 1024;
    localparam int FRAC_BITS_DEF    = 8;
    localparam int QUEUE_DEPTH      = 4;

    localparam int SIZE_W      = 11;
    localparam int HEIGHT_W    = 16;
    localparam int INDEX_W     = 20;
    localparam int POINT_W     = 18;
    localparam int OUT_W       = 32;
    localparam int CFG_INDEX_W = 1;
    localparam int KIND_W      = 2;

    localparam logic [SIZE_W-1:0] MAP_SIZE_RESET   = 11'd1024;
    localparam logic [SIZE_W-1:0] MAP_SIZE_MIN     = 11'd2;
    localparam logic [OUT_W-1:0]  MAX_HEIGHT_RESET = 32'd65536;

    // Full-scale raw sample; the final scale divides by this times 2^16.
    localparam logic [HEIGHT_W:0] FULL_SCALE = 17'h0FFFF;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic [CFG_INDEX_W-1:0] REG_MAP_SIZE   = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_HEIGHT = 1'b1;

    typedef enum logic [KIND_W-1:0] {
        KIND_WRITE,
        KIND_QUERY,
        KIND_OOR
    } t_kind;

    // Width of one queued item: kind, write address and data, four
    // coordinates and two fraction weights.
    function automatic int entry_w(input int m, input int f);
        return KIND_W + $clog2(m * m) + HEIGHT_W + 4 * $clog2(m) + 2 * f;
    endfunction

endpackage

// File: hdl/hmbs_ram.sv
// Generic simple dual-port RAM: one write port, two registered read ports.
`timescale 1ns / 1ps

module hmbs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata_a <= r_mem[i_raddr_a];
            o_rdata_b <= r_mem[i_raddr_b];
        end
    end

endmodule

// File: hdl/hmbs_fifo.sv
// Short item queue between the classifying front and the sampling back.
`timescale 1ns / 1ps

module hmbs_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);

    localparam int PW  = $clog2(DEPTH);
    localparam int CNW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr_ptr;
    logic [PW-1:0]    r_rd_ptr;
    logic [CNW-1:0]   r_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == CNW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

// File: hdl/hmbs_front.sv
// Front end: takes input items, checks them against the map, and queues them.
`timescale 1ns / 1ps

module hmbs_front #(
    parameter int MAP_SIDE_MAX = hmbs_pkg::MAP_SIDE_MAX_DEF,
    parameter int FRAC_BITS    = hmbs_pkg::FRAC_BITS_DEF
) (
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic                              i_op,
    input  logic [hmbs_pkg::INDEX_W-1:0]      i_cell_index,
    input  logic [hmbs_pkg::HEIGHT_W-1:0]     i_cell_height,
    input  logic [hmbs_pkg::POINT_W-1:0]      i_point_x,
    input  logic [hmbs_pkg::POINT_W-1:0]      i_point_y,
    input  logic [hmbs_pkg::SIZE_W-1:0]       i_size,
    input  logic                              i_full,
    output logic                              o_push,
    output logic [hmbs_pkg::entry_w(MAP_SIDE_MAX, FRAC_BITS)-1:0] o_entry
);

    localparam int CW  = $clog2(MAP_SIDE_MAX);
    localparam int AW  = $clog2(MAP_SIDE_MAX * MAP_SIDE_MAX);
    localparam int XIW = hmbs_pkg::POINT_W - FRAC_BITS;
    localparam int ARW = 2 * hmbs_pkg::SIZE_W;

    typedef struct packed {
        hmbs_pkg::t_kind                   kind;
        logic [AW-1:0]                     waddr;
        logic [hmbs_pkg::HEIGHT_W-1:0]     wdata;
        logic [CW-1:0]                     x;
        logic [CW-1:0]                     y;
        logic [CW-1:0]                     nx;
        logic [CW-1:0]                     ny;
        logic [FRAC_BITS-1:0]              fx;
        logic [FRAC_BITS-1:0]              fy;
    } t_entry;

    logic [XIW-1:0] xi;
    logic [XIW-1:0] yi;
    logic [ARW-1:0] area;
    logic           write_ok;
    logic           outside;
    t_entry         entry;

    assign xi       = i_point_x[hmbs_pkg::POINT_W-1:FRAC_BITS];
    assign yi       = i_point_y[hmbs_pkg::POINT_W-1:FRAC_BITS];
    assign area     = ARW'(32'(i_size) * 32'(i_size));
    assign write_ok = (32'(i_cell_index) < 32'(area));
    assign outside  = (32'(xi) >= 32'(i_size)) || (32'(yi) >= 32'(i_size));

    always_comb begin
        if (i_op == hmbs_pkg::OP_WRITE) begin
            entry.kind = hmbs_pkg::KIND_WRITE;
        end else if (outside) begin
            entry.kind = hmbs_pkg::KIND_OOR;
        end else begin
            entry.kind = hmbs_pkg::KIND_QUERY;
        end
        entry.waddr = AW'(i_cell_index);
        entry.wdata = i_cell_height;
        entry.x     = CW'(xi);
        entry.y     = CW'(yi);
        // Clamp the right and lower neighbors to the last column and row.
        entry.nx    = (32'(xi) + 32'd1 == 32'(i_size)) ? CW'(xi) : CW'(32'(xi) + 32'd1);
        entry.ny    = (32'(yi) + 32'd1 == 32'(i_size)) ? CW'(yi) : CW'(32'(yi) + 32'd1);
        entry.fx    = i_point_x[FRAC_BITS-1:0];
        entry.fy    = i_point_y[FRAC_BITS-1:0];
    end

    assign o_ready = !i_full;
    // Drop writes that fall outside the map.
    assign o_push  = i_valid && !i_full && ((i_op != hmbs_pkg::OP_WRITE) || write_ok);
    assign o_entry = entry;

endmodule

// File: hdl/hmbs_back.sv
// Back end: store access, bilinear blend, scaling pipeline and result register.
`timescale 1ns / 1ps

module hmbs_back #(
    parameter int MAP_SIDE_MAX = hmbs_pkg::MAP_SIDE_MAX_DEF,
    parameter int FRAC_BITS    = hmbs_pkg::FRAC_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [hmbs_pkg::SIZE_W-1:0]   i_size,
    input  logic [hmbs_pkg::OUT_W-1:0]    i_max_height,
    input  logic                          i_entry_valid,
    output logic                          o_entry_ready,
    input  logic [hmbs_pkg::entry_w(MAP_SIDE_MAX, FRAC_BITS)-1:0] i_entry,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [hmbs_pkg::OUT_W-1:0]    o_height,
    output logic                          o_out_of_range
);

    localparam int CW  = $clog2(MAP_SIDE_MAX);
    localparam int AW  = $clog2(MAP_SIDE_MAX * MAP_SIDE_MAX);
    localparam int HW  = hmbs_pkg::HEIGHT_W;
    localparam int RW  = HW + FRAC_BITS;
    localparam int BW  = HW + 2 * FRAC_BITS;
    localparam int SHR = (2 * FRAC_BITS >= 16) ? 2 * FRAC_BITS - 16 : 0;
    localparam int SHL = (2 * FRAC_BITS < 16) ? 16 - 2 * FRAC_BITS : 0;
    localparam logic [FRAC_BITS:0] FRAC_ONE = {1'b1, {FRAC_BITS{1'b0}}};

    typedef struct packed {
        hmbs_pkg::t_kind                   kind;
        logic [AW-1:0]                     waddr;
        logic [HW-1:0]                     wdata;
        logic [CW-1:0]                     x;
        logic [CW-1:0]                     y;
        logic [CW-1:0]                     nx;
        logic [CW-1:0]                     ny;
        logic [FRAC_BITS-1:0]              fx;
        logic [FRAC_BITS-1:0]              fy;
    } t_entry;

    function automatic logic [RW-1:0] blend(input logic [HW-1:0] a,
                                            input logic [HW-1:0] b,
                                            input logic [FRAC_BITS-1:0] f);
        logic [FRAC_BITS:0] w;
        w = FRAC_ONE - {1'b0, f};
        return RW'(a * w) + RW'(b * f);
    endfunction

    t_entry entry_in;
    logic   advance;

    // Stage M: row offsets
    logic          r_m_valid;
    t_entry        r_m;
    logic [AW-1:0] r_m_row0;
    logic [AW-1:0] r_m_row1;
    // Stage A: store access, top row then bottom row for an in-range query
    logic          r_a_valid;
    logic          r_a_phase;
    t_entry        r_a;
    logic [AW-1:0] r_a_row0;
    logic [AW-1:0] r_a_row1;
    logic          a_query;
    logic          a_done;
    logic          a_free;
    logic          m_to_a;
    logic          m_free;
    logic [AW-1:0] a_row;
    // Store port signals
    logic          ram_we;
    logic          ram_re;
    logic [AW-1:0] ram_raddr_a;
    logic [AW-1:0] ram_raddr_b;
    logic [HW-1:0] ram_rdata_a;
    logic [HW-1:0] ram_rdata_b;
    // Stage R: tags for the read data
    logic                 r_r_valid;
    logic                 r_r_last;
    logic                 r_r_oor;
    logic [FRAC_BITS-1:0] r_r_fx;
    logic [FRAC_BITS-1:0] r_r_fy;
    logic [RW-1:0]        r_top;
    // Stage D: row blends
    logic                 r_d_valid;
    logic                 r_d_oor;
    logic [RW-1:0]        r_d_r0;
    logic [RW-1:0]        r_d_r1;
    logic [FRAC_BITS-1:0] r_d_fy;
    // Stage E: column blend
    logic          r_e_valid;
    logic          r_e_oor;
    logic [BW-1:0] r_e_b;
    logic [31:0]   b16;
    // Stage F: scale product
    logic          r_f_valid;
    logic          r_f_oor;
    logic [63:0]   r_f_p;
    // Stages G1, G2: division by 65535 * 65536 as folded sums
    logic          r_g1_valid;
    logic          r_g1_oor;
    logic [31:0]   r_g1_q;
    logic [32:0]   r_g1_a;
    logic [16:0]   g2_q;
    logic          r_g2_valid;
    logic          r_g2_oor;
    logic [31:0]   r_g2_q;
    logic [17:0]   r_g2_a;
    logic [1:0]    g3_q;
    logic [16:0]   g3_a;
    logic [31:0]   quotient;
    // Result register
    logic          r_out_valid;
    logic [31:0]   r_height;
    logic          r_oor;

    assign entry_in = t_entry'(i_entry);
    assign advance  = !r_out_valid || i_ready;

    assign a_query = (r_a.kind == hmbs_pkg::KIND_QUERY);
    assign a_done  = r_a_valid && (!a_query || r_a_phase);
    assign a_free  = !r_a_valid || (advance && a_done);
    assign m_to_a  = r_m_valid && a_free;
    assign m_free  = !r_m_valid || m_to_a;
    assign o_entry_ready = m_free;

    assign a_row       = r_a_phase ? r_a_row1 : r_a_row0;
    assign ram_raddr_a = AW'(a_row + AW'(r_a.x));
    assign ram_raddr_b = AW'(a_row + AW'(r_a.nx));
    assign ram_we      = advance && r_a_valid && (r_a.kind == hmbs_pkg::KIND_WRITE);
    assign ram_re      = advance && r_a_valid && a_query;

    hmbs_ram #(
        .WIDTH (HW),
        .DEPTH (MAP_SIDE_MAX * MAP_SIDE_MAX)
    ) u_store (
        .i_clk     (i_clk),
        .i_we      (ram_we),
        .i_waddr   (r_a.waddr),
        .i_wdata   (r_a.wdata),
        .i_re      (ram_re),
        .i_raddr_a (ram_raddr_a),
        .i_raddr_b (ram_raddr_b),
        .o_rdata_a (ram_rdata_a),
        .o_rdata_b (ram_rdata_b)
    );

    always_comb begin
        if (SHR > 0) begin
            b16 = 32'(r_e_b >> SHR);
        end else begin
            b16 = 32'(r_e_b) << SHL;
        end
    end

    assign g2_q     = r_g1_a[32:16];
    assign g3_q     = r_g2_a[17:16];
    assign g3_a     = 17'(g3_q) + 17'(r_g2_a[15:0]);
    assign quotient = r_g2_q + 32'(g3_q) + 32'(g3_a >= hmbs_pkg::FULL_SCALE);

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid   <= 1'b0;
            r_a_valid   <= 1'b0;
            r_a_phase   <= 1'b0;
            r_r_valid   <= 1'b0;
            r_d_valid   <= 1'b0;
            r_e_valid   <= 1'b0;
            r_f_valid   <= 1'b0;
            r_g1_valid  <= 1'b0;
            r_g2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (m_free) begin
                r_m_valid <= i_entry_valid;
            end
            if (m_to_a) begin
                r_a_valid <= 1'b1;
                r_a_phase <= 1'b0;
            end else if (a_free) begin
                r_a_valid <= 1'b0;
                r_a_phase <= 1'b0;
            end else if (advance && r_a_valid) begin
                // Top row issued, bottom row next
                r_a_phase <= 1'b1;
            end
            if (advance) begin
                r_r_valid   <= r_a_valid && (r_a.kind != hmbs_pkg::KIND_WRITE);
                r_d_valid   <= r_r_valid && r_r_last;
                r_e_valid   <= r_d_valid;
                r_f_valid   <= r_e_valid;
                r_g1_valid  <= r_f_valid;
                r_g2_valid  <= r_g1_valid;
                r_out_valid <= r_g2_valid;
            end
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        if (m_free && i_entry_valid) begin
            r_m      <= entry_in;
            r_m_row0 <= AW'(32'(entry_in.y) * 32'(i_size));
            r_m_row1 <= AW'(32'(entry_in.ny) * 32'(i_size));
        end
        if (m_to_a) begin
            r_a      <= r_m;
            r_a_row0 <= r_m_row0;
            r_a_row1 <= r_m_row1;
        end
        if (advance) begin
            r_r_last <= (r_a.kind == hmbs_pkg::KIND_OOR) || r_a_phase;
            r_r_oor  <= (r_a.kind == hmbs_pkg::KIND_OOR);
            r_r_fx   <= r_a.fx;
            r_r_fy   <= r_a.fy;
            if (r_r_valid && !r_r_last) begin
                r_top <= blend(ram_rdata_a, ram_rdata_b, r_r_fx);
            end
            r_d_oor  <= r_r_oor;
            r_d_r0   <= r_top;
            r_d_r1   <= blend(ram_rdata_a, ram_rdata_b, r_r_fx);
            r_d_fy   <= r_r_fy;
            r_e_oor  <= r_d_oor;
            r_e_b    <= BW'(r_d_r0 * (FRAC_ONE - {1'b0, r_d_fy})) + BW'(r_d_r1 * r_d_fy);
            r_f_oor  <= r_e_oor;
            r_f_p    <= 64'(b16) * 64'(i_max_height);
            // p / 2^16 = 65535 * q1 + a1, with q1 = p[63:32], a1 = q1 + p[31:16]
            r_g1_oor <= r_f_oor;
            r_g1_q   <= r_f_p[63:32];
            r_g1_a   <= {1'b0, r_f_p[63:32]} + {17'b0, r_f_p[31:16]};
            r_g2_oor <= r_g1_oor;
            r_g2_q   <= r_g1_q + 32'(g2_q);
            r_g2_a   <= 18'(g2_q) + 18'(r_g1_a[15:0]);
            r_oor    <= r_g2_oor;
            r_height <= r_g2_oor ? '0 : quotient;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_height       = r_height;
    assign o_out_of_range = r_oor;

    a_store_port_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(ram_we && ram_re))
        else $error("store written and read in the same cycle");

    a_phase_query: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_a_phase |-> (r_a_valid && r_a.kind == hmbs_pkg::KIND_QUERY))
        else $error("second read phase without an in-range query");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_ready) |=> ($stable(r_a_phase) && $stable(r_g2_q)
                                       && $stable(r_e_b)))
        else $error("pipeline moved while the result was stalled");

endmodule

// File: hdl/heightmap_bilinear_sampler.sv
// Top level: configuration registers, front end, item queue and back end.
`timescale 1ns / 1ps

// Heightmap bilinear sampler.
// Input channel (i_valid/o_ready): op 0 writes cell_height at cell_index, op 1
// queries point_x/point_y (fixed point, FRAC_BITS fraction bits). Writes outside
// the current map are dropped and no write gives a result.
// Output channel (o_valid/i_ready): one item per query, the bilinear height in
// Q16.16 scaled by max_height / 65535, or zero with o_out_of_range set.
// Configuration channel (i_cfg_valid/o_cfg_ready): index 0 map_size, index 1
// max_height; write only while no item is in flight.
// Path: a query moves from the queue through stages M, A, R, D, E, F, G1 and G2
// to the result register; a write ends at the store in stage A.
// Store use: an in-range query reads the store in stage A a row at a time, as its four
// samples come out of the store's two read ports, top row first; a write makes a
// single store write and an out-of-range query reads nothing.
// Reset: empties the queue and pipeline and sets map_size 1024 and
// max_height 65536; the sample store keeps its contents, undefined until
// written.
// Stall: while a result waits with i_ready low the pipeline holds; the queue keeps taking items
// until it is full, then o_ready drops.

module heightmap_bilinear_sampler #(
    parameter int MAP_SIDE_MAX = hmbs_pkg::MAP_SIDE_MAX_DEF,
    parameter int FRAC_BITS    = hmbs_pkg::FRAC_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic                              i_op,
    input  logic [hmbs_pkg::INDEX_W-1:0]      i_cell_index,
    input  logic [hmbs_pkg::HEIGHT_W-1:0]     i_cell_height,
    input  logic [hmbs_pkg::POINT_W-1:0]      i_point_x,
    input  logic [hmbs_pkg::POINT_W-1:0]      i_point_y,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [hmbs_pkg::OUT_W-1:0]        o_height,
    output logic                              o_out_of_range,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [hmbs_pkg::CFG_INDEX_W-1:0]  i_cfg_index,
    input  logic [hmbs_pkg::OUT_W-1:0]        i_cfg_data
);

    localparam int EW = hmbs_pkg::entry_w(MAP_SIDE_MAX, FRAC_BITS);

    logic [hmbs_pkg::SIZE_W-1:0] r_map_size;
    logic [hmbs_pkg::OUT_W-1:0]  r_max_height;
    logic [hmbs_pkg::SIZE_W-1:0] size_eff;

    logic          push;
    logic          full;
    logic [EW-1:0] push_entry;
    logic          q_valid;
    logic          q_pop;
    logic [EW-1:0] q_entry;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map_size   <= hmbs_pkg::MAP_SIZE_RESET;
            r_max_height <= hmbs_pkg::MAX_HEIGHT_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                hmbs_pkg::REG_MAP_SIZE:   r_map_size   <= i_cfg_data[hmbs_pkg::SIZE_W-1:0];
                hmbs_pkg::REG_MAX_HEIGHT: r_max_height <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Clamp the side length into the supported range.
    always_comb begin
        size_eff = r_map_size;
        if (r_map_size < hmbs_pkg::MAP_SIZE_MIN) begin
            size_eff = hmbs_pkg::MAP_SIZE_MIN;
        end else if (32'(r_map_size) > 32'(MAP_SIDE_MAX)) begin
            size_eff = hmbs_pkg::SIZE_W'(MAP_SIDE_MAX);
        end
    end

    hmbs_front #(
        .MAP_SIDE_MAX (MAP_SIDE_MAX),
        .FRAC_BITS    (FRAC_BITS)
    ) u_front (
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_op          (i_op),
        .i_cell_index  (i_cell_index),
        .i_cell_height (i_cell_height),
        .i_point_x     (i_point_x),
        .i_point_y     (i_point_y),
        .i_size        (size_eff),
        .i_full        (full),
        .o_push        (push),
        .o_entry       (push_entry)
    );

    hmbs_fifo #(
        .WIDTH (EW),
        .DEPTH (hmbs_pkg::QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_entry),
        .o_full  (full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_entry)
    );

    hmbs_back #(
        .MAP_SIDE_MAX (MAP_SIDE_MAX),
        .FRAC_BITS    (FRAC_BITS)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_size         (size_eff),
        .i_max_height   (r_max_height),
        .i_entry_valid  (q_valid),
        .o_entry_ready  (q_pop),
        .i_entry        (q_entry),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_height       (o_height),
        .o_out_of_range (o_out_of_range)
    );

endmodule

// File: verif/tb.sv
// Testbench for the heightmap bilinear sampler, checked against a bilinear height predictor.
`timescale 1ns / 1ps

module tb;
    import hmbs_pkg::*;

    localparam int FB              = FRAC_BITS_DEF;
    localparam int FRAC_ONE        = 1 << FB;
    localparam int COORD_TOP       = (1 << (POINT_W - FB)) - 1;
    localparam int INDEX_TOP       = (1 << INDEX_W) - 1;
    localparam int SETTLE_CYCLES   = 30;
    localparam int STALL_LIMIT     = 2000;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int PHASES          = 9;

    typedef struct packed {
        logic [OUT_W-1:0] height;
        logic             oor;
    } height_exp_t;

    class height_scoreboard;
        bit [HEIGHT_W-1:0] sample_mem [int unsigned];
        bit [SIZE_W-1:0]   map_size;
        bit [OUT_W-1:0]    max_height;
        height_exp_t       pending [$];
        int                errors;
        int                oor_seen;

        function new();
            map_size   = MAP_SIZE_RESET;
            max_height = MAX_HEIGHT_RESET;
            errors     = 0;
            oor_seen   = 0;
        endfunction

        function int unsigned side_len();
            if (map_size < 2) return 2;
            if (map_size > MAP_SIDE_MAX_DEF) return MAP_SIDE_MAX_DEF;
            return map_size;
        endfunction

        function void set_register(logic [CFG_INDEX_W-1:0] idx, logic [OUT_W-1:0] data);
            if (idx == REG_MAP_SIZE) begin
                map_size = data[SIZE_W-1:0];
            end else begin
                max_height = data;
            end
        endfunction

        // Store a write or predict the height that a query yields.
        function void note_item(logic op_in, logic [INDEX_W-1:0] idx,
                                logic [HEIGHT_W-1:0] h,
                                logic [POINT_W-1:0] px, logic [POINT_W-1:0] py);
            int unsigned     side, x, y, nx, ny;
            longint unsigned fx, fy, r0, r1, blend, b16, scale_div;
            height_exp_t     res;
            side = side_len();
            if (op_in == OP_WRITE) begin
                if (idx < side * side) sample_mem[idx] = h;
                return;
            end
            x  = px >> FB;
            y  = py >> FB;
            fx = px & (FRAC_ONE - 1);
            fy = py & (FRAC_ONE - 1);
            if (x >= side || y >= side) begin
                res.height = '0;
                res.oor    = 1'b1;
            end else begin
                nx = (x + 1 < side) ? x + 1 : side - 1;
                ny = (y + 1 < side) ? y + 1 : side - 1;
                r0 = longint'(sample_mem[x + y * side]) * (FRAC_ONE - fx)
                   + longint'(sample_mem[nx + y * side]) * fx;
                r1 = longint'(sample_mem[x + ny * side]) * (FRAC_ONE - fx)
                   + longint'(sample_mem[nx + ny * side]) * fx;
                blend = r0 * (FRAC_ONE - fy) + r1 * fy;
                // bring the blend to 16 fraction bits
                if (2 * FB >= 16) begin
                    b16 = blend >> (2 * FB - 16);
                end else begin
                    b16 = blend << (16 - 2 * FB);
                end
                scale_div  = longint'(FULL_SCALE) << 16;
                res.height = OUT_W'((b16 * longint'(max_height)) / scale_div);
                res.oor    = 1'b0;
            end
            pending.push_back(res);
        endfunction

        function void check_item(logic [OUT_W-1:0] h, logic oor);
            height_exp_t want;
            if (pending.size() == 0) begin
                $error("result with no query waiting: height %h out_of_range %b", h, oor);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (oor === 1'b1) oor_seen++;
            if (h !== want.height) begin
                $error("height: expected %h, actual %h", want.height, h);
                errors++;
            end
            if (oor !== want.oor) begin
                $error("out_of_range: expected %b, actual %b", want.oor, oor);
                errors++;
            end
        endfunction
    endclass

    logic                   clk;
    logic                   rst_n;
    logic                   item_valid;
    logic                   item_ready;
    logic                   op;
    logic [INDEX_W-1:0]     cell_index;
    logic [HEIGHT_W-1:0]    cell_height;
    logic [POINT_W-1:0]     point_x;
    logic [POINT_W-1:0]     point_y;
    logic                   res_valid;
    logic                   res_ready;
    logic [OUT_W-1:0]       res_height;
    logic                   res_oor;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [OUT_W-1:0]       cfg_data;

    height_scoreboard sb;
    int send_idle_pct;
    int recv_idle_pct;
    int hold_request;
    int hold_left;
    int quiet_cycles;
    int items_sent;
    int queries_sent;
    int writes_dropped;
    int settings;
    logic [SIZE_W-1:0] phase_size [PHASES];
    logic [OUT_W-1:0]  phase_max [PHASES];

    heightmap_bilinear_sampler i_dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_valid        (item_valid),
        .o_ready        (item_ready),
        .i_op           (op),
        .i_cell_index   (cell_index),
        .i_cell_height  (cell_height),
        .i_point_x      (point_x),
        .i_point_y      (point_y),
        .o_valid        (res_valid),
        .i_ready        (res_ready),
        .o_height       (res_height),
        .o_out_of_range (res_oor),
        .i_cfg_valid    (cfg_valid),
        .o_cfg_ready    (cfg_ready),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data)
    );

    always begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // Result side: check each accepted item, then pick the next ready level.
    always @(posedge clk) begin
        if (!rst_n) begin
            res_ready <= 1'b0;
        end else begin
            if (res_valid && res_ready) sb.check_item(res_height, res_oor);
            if (hold_request != 0) begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left != 0) begin
                hold_left--;
                res_ready <= 1'b0;
            end else begin
                res_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (item_valid && item_ready) || (res_valid && res_ready)
            || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("timeout: no item moved for %0d cycles", STALL_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic int unsigned pick_frac();
        int unsigned roll;
        roll = $urandom_range(3);
        if (roll == 0) return 0;
        if (roll == 1) return FRAC_ONE - 1;
        return $urandom_range(FRAC_ONE - 1);
    endfunction

    function automatic int unsigned pick_coord(int unsigned side);
        int unsigned roll;
        roll = $urandom_range(7);
        if (roll < 2) return side - 1;
        if (roll == 2) return 0;
        return $urandom_range(side - 1);
    endfunction

    function automatic logic [POINT_W-1:0] make_point(int unsigned coord);
        return POINT_W'((coord << FB) | pick_frac());
    endfunction

    task automatic send_item(input logic op_in, input logic [INDEX_W-1:0] idx,
                             input logic [HEIGHT_W-1:0] h,
                             input logic [POINT_W-1:0] px, input logic [POINT_W-1:0] py);
        int unsigned side;
        while ($urandom_range(99) < send_idle_pct) begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid  <= 1'b1;
        op          <= op_in;
        cell_index  <= idx;
        cell_height <= h;
        point_x     <= px;
        point_y     <= py;
        @(posedge clk);
        while (!item_ready) @(posedge clk);
        side = sb.side_len();
        if (op_in == OP_WRITE && idx >= side * side) begin
            writes_dropped++;
        end else begin
            items_sent++;
        end
        if (op_in == OP_QUERY) queries_sent++;
        sb.note_item(op_in, idx, h, px, py);
    endtask

    // Write any neighbor sample not yet stored, or all four when refresh is set, then send the query.
    task automatic query_point(input logic [POINT_W-1:0] px, input logic [POINT_W-1:0] py,
                               input bit refresh);
        int unsigned side, x, y, nx, ny;
        int unsigned cells [4];
        side = sb.side_len();
        x    = px >> FB;
        y    = py >> FB;
        if (x < side && y < side) begin
            nx    = (x + 1 < side) ? x + 1 : side - 1;
            ny    = (y + 1 < side) ? y + 1 : side - 1;
            cells = '{x + y * side, nx + y * side, x + ny * side, nx + ny * side};
            foreach (cells[k]) begin
                if (refresh || !sb.sample_mem.exists(cells[k])) begin
                    send_item(OP_WRITE, INDEX_W'(cells[k]), HEIGHT_W'($urandom),
                              POINT_W'($urandom), POINT_W'($urandom));
                end
            end
        end
        send_item(OP_QUERY, INDEX_W'($urandom), HEIGHT_W'($urandom), px, py);
    endtask

    task automatic drain();
        item_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [OUT_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        sb.set_register(idx, data);
    endtask

    task automatic configure(input logic [SIZE_W-1:0] size_val, input logic [OUT_W-1:0] max_val);
        drain();
        write_reg(REG_MAP_SIZE, OUT_W'(size_val));
        write_reg(REG_MAX_HEIGHT, max_val);
        cfg_valid <= 1'b0;
        settings++;
    endtask

    task automatic run_random(input int count, input bit hold, input bit pause);
        int unsigned side, roll, xi, yi;
        int          stop_at;
        bit          paused;
        stop_at = items_sent + count;
        paused  = 1'b0;
        if (hold) hold_request = HOLD_OFF_CYCLES;
        while (items_sent < stop_at) begin
            if (pause && !paused && items_sent >= stop_at - count / 2) begin
                drain();
                paused = 1'b1;
            end
            side = sb.side_len();
            roll = $urandom_range(99);
            if (roll < 55) begin
                query_point(make_point(pick_coord(side)), make_point(pick_coord(side)),
                            roll < 15);
            end else if (roll < 68) begin
                send_item(OP_WRITE, INDEX_W'($urandom_range(side * side - 1)),
                          HEIGHT_W'($urandom), POINT_W'($urandom), POINT_W'($urandom));
            end else if (roll < 80 && side <= COORD_TOP) begin
                // one coordinate past the map, the other anywhere
                xi = $urandom_range(COORD_TOP, side);
                yi = $urandom_range(1) ? $urandom_range(side - 1) : $urandom_range(COORD_TOP);
                if ($urandom_range(1)) begin
                    query_point(make_point(xi), make_point(yi), 1'b0);
                end else begin
                    query_point(make_point(yi), make_point(xi), 1'b0);
                end
            end else if (roll < 88 && side * side <= INDEX_TOP) begin
                send_item(OP_WRITE, INDEX_W'($urandom_range(INDEX_TOP, side * side)),
                          HEIGHT_W'($urandom), POINT_W'($urandom), POINT_W'($urandom));
            end else begin
                query_point(POINT_W'($urandom), POINT_W'($urandom), 1'b0);
            end
        end
    endtask

    initial begin
        rst_n       <= 1'b0;
        item_valid  <= 1'b0;
        op          <= OP_WRITE;
        cell_index  <= '0;
        cell_height <= '0;
        point_x     <= '0;
        point_y     <= '0;
        cfg_valid   <= 1'b0;
        cfg_index   <= REG_MAP_SIZE;
        cfg_data    <= '0;
        res_ready   <= 1'b0;
        sb             = new();
        send_idle_pct  = 9;
        recv_idle_pct  = 63;
        hold_request   = 0;
        hold_left      = 0;
        quiet_cycles   = 0;
        items_sent     = 0;
        queries_sent   = 0;
        writes_dropped = 0;
        settings       = 0;
        phase_size = '{11'd2, 11'd17, 11'd1, 11'd5, 11'd1024, 11'd100, 11'd3, 11'd2047, 11'd64};
        phase_max  = '{32'd65535, 32'hFFFF_FFFF, 32'd0, 32'd65536, 32'd0, 32'd0,
                       32'hFFFF_FFFF, 32'd1, 32'd0};
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Full-size map after reset: index extremes and clamped corner queries.
        send_item(OP_WRITE, '0, '1, '0, '0);
        send_item(OP_WRITE, INDEX_W'(INDEX_TOP), '0, '1, '1);
        query_point('0, '0, 1'b0);
        query_point('1, '1, 1'b0);
        query_point(POINT_W'((COORD_TOP << FB) | (FRAC_ONE - 1)), '0, 1'b0);

        // Size below range acts as 2; full-scale height.
        configure(11'd0, 32'hFFFF_FFFF);
        send_item(OP_WRITE, INDEX_W'(3), '1, '0, '0);
        send_item(OP_WRITE, INDEX_W'(4), '1, '0, '0);
        send_item(OP_WRITE, INDEX_W'(INDEX_TOP), '0, '0, '0);
        query_point(POINT_W'((1 << FB) | (FRAC_ONE / 2)), POINT_W'((1 << FB) | (FRAC_ONE - 1)),
                    1'b0);
        query_point(POINT_W'(2 << FB), '0, 1'b0);
        query_point('0, '1, 1'b0);
        query_point('0, '0, 1'b0);

        // Size above range acts as the largest map; zero height scale.
        configure(11'd2047, '0);
        query_point(POINT_W'((512 << FB) | 77), POINT_W'((300 << FB) | 200), 1'b1);

        for (int p = 0; p < PHASES; p++) begin
            if (p == 3) begin
                send_idle_pct = 63;
                recv_idle_pct = 9;
            end
            if (p == 6) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            configure(phase_size[p], (p % 3 == 2) ? OUT_W'($urandom) : phase_max[p]);
            run_random(85, p == 1, p == 4);
        end

        drain();
        $display("Run covered %0d items, %0d of them queries (%0d out of range), plus %0d",
                 items_sent, queries_sent, sb.oor_seen, writes_dropped);
        $display("dropped writes, over %0d register settings; %0d mismatches.",
                 settings + 1, sb.errors);
        if (sb.errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// File: filelist.f
hdl/hmbs_pkg.sv
hdl/hmbs_ram.sv
hdl/hmbs_fifo.sv
hdl/hmbs_front.sv
hdl/hmbs_back.sv
hdl/heightmap_bilinear_sampler.sv
verif/tb.sv
